/* hw/rtl/plnm_pkg.sv */
// ----------------------------------------------------------------------------
// plnm_pkg
// Shared sizes, codes and types for the palette light-level nearest match.
// ----------------------------------------------------------------------------
package plnm_pkg;

  localparam int LIGHT_LEVELS    = 16;
  localparam int PALETTE_ENTRIES = 256;

  localparam int CHAN_W   = 8;
  localparam int LEVEL_W  = 4;
  localparam int COLOR_W  = 8;
  localparam int NUM_CHAN = 3;

  localparam int IDX_W = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

  // darkening: floor(c * level / DARK_DIV) by reciprocal plus one correction
  localparam int DARK_DIV   = LIGHT_LEVELS - 1;
  localparam int PROD_W     = CHAN_W + LEVEL_W;
  localparam int RECIP_W    = PROD_W + 1;
  localparam int DARK_RECIP = (1 << PROD_W) / DARK_DIV;
  localparam int MULR_W     = PROD_W + RECIP_W;

  localparam int SQ_W   = 2 * CHAN_W;
  localparam int DIST_W = SQ_W + 2;
  localparam logic [DIST_W-1:0] NO_DIST = {DIST_W{1'b1}};

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef chan_t [NUM_CHAN-1:0] rgb_t;   // [2] red, [1] green, [0] blue

  typedef struct packed {
    logic             start;
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

endpackage

/* hw/rtl/plnm_dist.sv */
// ----------------------------------------------------------------------------
// plnm_dist
// Squared RGB distance and running minimum over one palette scan.
// ----------------------------------------------------------------------------
module plnm_dist import plnm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  scan_ctl_t        ctl,
  input  rgb_t             target,
  input  rgb_t             entry,
  output logic [IDX_W-1:0] best_idx,
  output logic             done
);

  chan_t             diff [NUM_CHAN];
  logic [SQ_W-1:0]   sq [NUM_CHAN];
  logic [IDX_W-1:0]  sq_idx;
  logic              sq_valid;
  logic              sq_last;
  logic [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0] best_dist;

  always_comb begin
    dist_sum = '0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      diff[k] = (target[k] > entry[k]) ? (target[k] - entry[k]) : (entry[k] - target[k]);
      dist_sum = dist_sum + DIST_W'(sq[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      sq[k] <= diff[k] * diff[k];
    end
    sq_idx <= ctl.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid  <= 1'b0;
      sq_last   <= 1'b0;
      done      <= 1'b0;
      best_dist <= NO_DIST;
      best_idx  <= '0;
    end else begin
      sq_valid <= ctl.valid && !ctl.start;
      sq_last  <= ctl.last;
      done     <= sq_valid && sq_last;
      if (ctl.start) begin
        best_dist <= NO_DIST;
      end else if (sq_valid && (dist_sum < best_dist)) begin
        // strict compare keeps the first entry on a tie
        best_dist <= dist_sum;
        best_idx  <= sq_idx;
      end
    end
  end

endmodule

/* hw/rtl/palette_light_level_nearest_match.sv */
// ----------------------------------------------------------------------------
// palette_light_level_nearest_match
// Palette store with a darken-and-search engine for colormap building.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | sink      | in_valid / in_stall | command, color_index, light_level,
//          |           |                     | red, green, blue
//  out     | source    | out_valid/out_stall | out_level, out_color, mapped_index
//
//  A palette write does not hold off the input; the next beat is taken at the
//  following edge. A query passes through the load, reciprocal, fix, scan and
//  done states to its result beat; the scan makes one palette read per cycle on
//  the single read port of the palette memory. in_stall drops as the result
//  beat is loaded; it is high for the whole query, longer if the previous
//  result still waits; a finished result waits in the output register while
//  new beats are accepted.
//  Reset clears control state only; the palette holds garbage until written.
// ----------------------------------------------------------------------------
module palette_light_level_nearest_match import plnm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [COLOR_W-1:0] color_index,
  input  logic [LEVEL_W-1:0] light_level,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_level,
  output logic [COLOR_W-1:0] out_color,
  output logic [COLOR_W-1:0] mapped_index
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RECIP,
    S_FIX,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  rgb_t palette [PALETTE_ENTRIES];
  rgb_t rd_data;
  rgb_t wr_rgb;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic             accept;
  logic             issue;

  logic [LEVEL_W-1:0] q_level;
  logic [COLOR_W-1:0] q_color;
  logic [LEVEL_W-1:0] q_eff;
  logic               q_oob;
  logic [LEVEL_W-1:0] eff_level;

  logic [PROD_W-1:0] chan_prod  [NUM_CHAN];
  logic [MULR_W-1:0] recip_prod [NUM_CHAN];
  logic [PROD_W-1:0] quo [NUM_CHAN];
  logic [PROD_W-1:0] rem [NUM_CHAN];
  rgb_t              dark;
  rgb_t              target;

  logic [CNT_W-1:0] scan_cnt;
  logic             rd_valid;
  logic             rd_last;
  logic [IDX_W-1:0] rd_idx;

  scan_ctl_t        scan_ctl;
  logic [IDX_W-1:0] best_idx;
  logic             scan_done;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wr_rgb   = {red, green, blue};
  assign wr_en    = accept && (command == CMD_WRITE) && (int'(color_index) < PALETTE_ENTRIES);
  assign issue    = (state == S_SCAN) && (scan_cnt != CNT_W'(PALETTE_ENTRIES));
  assign rd_addr  = issue ? scan_cnt[IDX_W-1:0] : color_index[IDX_W-1:0];

  assign eff_level = (int'(light_level) > LIGHT_LEVELS - 1) ?
                     LEVEL_W'(LIGHT_LEVELS - 1) : light_level;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette[color_index[IDX_W-1:0]] <= wr_rgb;
    end
    rd_data <= palette[rd_addr];
  end

  // finish the divide: the reciprocal estimate is at most one short
  always_comb begin
    for (int k = 0; k < NUM_CHAN; k++) begin
      quo[k]  = recip_prod[k][PROD_W +: PROD_W];
      rem[k]  = chan_prod[k] - PROD_W'(quo[k] * DARK_DIV);
      dark[k] = (rem[k] >= PROD_W'(DARK_DIV)) ? CHAN_W'(quo[k] + 1'b1) : CHAN_W'(quo[k]);
    end
  end

  always_comb begin
    scan_ctl.start = (state == S_FIX);
    scan_ctl.valid = rd_valid;
    scan_ctl.last  = rd_last;
    scan_ctl.idx   = rd_idx;
  end

  plnm_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .target   (target),
    .entry    (rd_data),
    .best_idx (best_idx),
    .done     (scan_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_valid  <= 1'b0;
      rd_last   <= 1'b0;
      scan_cnt  <= '0;
    end else begin
      rd_valid <= issue;
      rd_last  <= issue && (scan_cnt == CNT_W'(PALETTE_ENTRIES - 1));
      rd_idx   <= scan_cnt[IDX_W-1:0];
      // drop a taken result beat unless a new one replaces it this cycle
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (command == CMD_QUERY)) begin
            q_level <= light_level;
            q_color <= color_index;
            q_eff   <= eff_level;
            q_oob   <= !(int'(color_index) < PALETTE_ENTRIES);
            state   <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int k = 0; k < NUM_CHAN; k++) begin
            chan_prod[k] <= q_oob ? '0 : PROD_W'(rd_data[k]) * PROD_W'(q_eff);
          end
          state <= S_RECIP;
        end
        S_RECIP: begin
          for (int k = 0; k < NUM_CHAN; k++) begin
            recip_prod[k] <= MULR_W'(chan_prod[k]) * MULR_W'(DARK_RECIP);
          end
          state <= S_FIX;
        end
        S_FIX: begin
          target   <= dark;
          scan_cnt <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (scan_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            out_level    <= q_level;
            out_color    <= q_color;
            mapped_index <= COLOR_W'(best_idx);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/plnm_checker.sv */
// ----------------------------------------------------------------------------
// plnm_checker
// Port-level checks for the palette light-level nearest match.
// ----------------------------------------------------------------------------
module plnm_checker import plnm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               command,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] out_level,
  input logic [COLOR_W-1:0] out_color,
  input logic [COLOR_W-1:0] mapped_index
);

  // a query beat blocks the input for the scan
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (command == CMD_QUERY)) |=> in_stall)
    else $error("input not held off after a query beat");

  // a palette write does not hold off the input
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (command == CMD_WRITE)) |=> !in_stall)
    else $error("input held off after a palette write");

  // a fresh result only comes out of a running query
  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no query in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_level) && $stable(out_color) && $stable(mapped_index)))
    else $error("stalled result beat changed");

endmodule

bind palette_light_level_nearest_match plnm_checker u_plnm_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .command      (command),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_level    (out_level),
  .out_color    (out_color),
  .mapped_index (mapped_index)
);
